FILE: hdl/etdnr_pkg.sv
// Shared constants and controller/datapath interface types for the NRZI DPLL receiver.
`default_nettype none
package etdnr_pkg;

	// Microsecond clock wraps once a second
	localparam int unsigned USEC_WRAP  = 1000000;
	localparam int unsigned USEC_HALF  = 500000;

	// Field and register widths
	localparam int unsigned TS_W       = 20;
	localparam int unsigned PERIOD_W   = 12;
	localparam int unsigned WORD_W     = 16;
	localparam int unsigned SHIFT_W    = WORD_W + 1;
	localparam int unsigned VOTE_W     = 16;
	localparam int unsigned TD_W       = 22;
	localparam int unsigned CFG_IDX_W  = 2;

	// Reset values and vote constants
	localparam int unsigned PERIOD_RESET = 833;
	localparam int unsigned VOTE_WINDOW  = 120;
	localparam int          VOTE_SEED    = 2;
	localparam int          VOTE_LATE    = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOFT_CARRIER  = 2'd1;

	localparam int unsigned MAX_WORDS_DEFAULT = 63;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;      // latch a new event, compute raw phase error
		logic fold;         // bring phase error into half-second window
		logic step;         // advance one bit period
		logic vote;         // rotate vote windows if countdown expired
		logic trans;        // apply level-change nudge and vote
		logic rd_issue;     // read next buffered word
		logic load_word;    // push buffered word into output register
		logic load_status;  // push status request into output register
	} etdnr_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic fold_needed;
		logic step_needed;
		logic more_words;
		logic out_free;
	} etdnr_stat_t;

endpackage
`default_nettype wire

FILE: hdl/etdnr_ctrl.sv
// Sequencer for the NRZI DPLL receiver: fold, per-period loop, vote, transition, unload.
`default_nettype none
module etdnr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire etdnr_pkg::etdnr_stat_t stat,
	output etdnr_pkg::etdnr_cmd_t     cmd
);
	import etdnr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FOLD = 3'd1;
	localparam logic [2:0] ST_LOOP = 3'd2;
	localparam logic [2:0] ST_VOTE = 3'd3;
	localparam logic [2:0] ST_TRAN = 3'd4;
	localparam logic [2:0] ST_RD   = 3'd5;
	localparam logic [2:0] ST_LOAD = 3'd6;
	localparam logic [2:0] ST_STAT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (stat.fold_needed) cmd.fold = 1'b1;
				else state_d = ST_LOOP;
			end
			ST_LOOP: begin
				if (stat.step_needed) cmd.step = 1'b1;
				else state_d = ST_VOTE;
			end
			ST_VOTE: begin
				cmd.vote = 1'b1;
				state_d  = ST_TRAN;
			end
			ST_TRAN: begin
				cmd.trans = 1'b1;
				state_d   = ST_RD;
			end
			ST_RD: begin
				if (stat.more_words) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_LOAD;
				end else begin
					state_d = ST_STAT;
				end
			end
			ST_LOAD: begin
				if (stat.out_free) begin
					cmd.load_word = 1'b1;
					state_d       = ST_RD;
				end
			end
			ST_STAT: begin
				if (stat.out_free) begin
					cmd.load_status = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

FILE: hdl/etdnr_dp.sv
// Datapath: phase error, bit clock phase, sentinel shifter, vote windows, word buffer, output register.
`default_nettype none
module etdnr_dp #(
	parameter int unsigned MAX_WORDS = etdnr_pkg::MAX_WORDS_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire etdnr_pkg::etdnr_cmd_t                cmd,
	output etdnr_pkg::etdnr_stat_t                    stat,
	input  wire logic [etdnr_pkg::PERIOD_W-1:0]       bit_period,
	input  wire logic                                 soft_enable,
	input  wire logic [etdnr_pkg::TS_W-1:0]           timestamp_us,
	input  wire logic                                 line_level,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [etdnr_pkg::WORD_W-1:0]              received_word,
	output logic                                      word_valid,
	output logic                                      carrier,
	output logic                                      overrun,
	output logic                                      last
);
	import etdnr_pkg::*;

	localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int unsigned CW = $clog2(MAX_WORDS + 1);

	// Working registers
	logic signed [TD_W-1:0]   td_q;
	logic                     lvl_q;
	logic [TS_W-1:0]          phase_q;
	logic [SHIFT_W-1:0]       shifter_q;
	logic                     prev_level_q;
	logic signed [VOTE_W-1:0] countdown_q;
	logic signed [VOTE_W-1:0] vote_cur_q;
	logic signed [VOTE_W-1:0] vote_prev_q;
	logic signed [VOTE_W-1:0] vote_old_q;
	logic                     carrier_q;
	logic [CW-1:0]            n_q;
	logic [CW-1:0]            rp_q;
	logic                     ovr_q;
	logic [WORD_W-1:0]        rd_data_q;
	logic [WORD_W-1:0]        word_mem [MAX_WORDS];

	// Output register
	logic                     out_valid_q;
	logic [WORD_W-1:0]        word_q;
	logic                     word_valid_q;
	logic                     carrier_out_q;
	logic                     overrun_q;
	logic                     last_q;

	// Effective period and its fractions
	logic [PERIOD_W-1:0]      per;
	logic signed [TD_W-1:0]   per_s, b2_s, b4_s;
	logic [PERIOD_W-1:0]      b8;
	assign per   = (bit_period == '0) ? PERIOD_W'(1) : bit_period;
	assign per_s = TD_W'(per);
	assign b2_s  = TD_W'(per >> 1);
	assign b4_s  = TD_W'(per >> 2);
	assign b8    = per >> 3;

	// Raw phase error of a new event
	logic signed [TD_W-1:0] td_raw;
	assign td_raw = TD_W'(USEC_WRAP) + TD_W'(timestamp_us) - TD_W'(phase_q);

	// Phase advanced by one period, modulo one second
	logic [TS_W:0] ph_step_sum;
	logic [TS_W-1:0] ph_step;
	assign ph_step_sum = {1'b0, phase_q} + (TS_W+1)'(per);
	assign ph_step = (ph_step_sum >= (TS_W+1)'(USEC_WRAP))
		? TS_W'(ph_step_sum - (TS_W+1)'(USEC_WRAP)) : TS_W'(ph_step_sum);

	// Phase nudged by an eighth period either way
	logic [TS_W:0]   ph_late_sum;
	logic [TS_W-1:0] ph_nudge;
	assign ph_late_sum = {1'b0, phase_q} + (TS_W+1)'(b8);
	always_comb begin
		if (td_q > 0) begin
			ph_nudge = (ph_late_sum >= (TS_W+1)'(USEC_WRAP))
				? TS_W'(ph_late_sum - (TS_W+1)'(USEC_WRAP)) : TS_W'(ph_late_sum);
		end else if (phase_q < TS_W'(b8)) begin
			ph_nudge = TS_W'((TS_W+1)'(phase_q) + (TS_W+1)'(USEC_WRAP) - (TS_W+1)'(b8));
		end else begin
			ph_nudge = phase_q - TS_W'(b8);
		end
	end

	// Transition timing vote, saturated
	logic signed [TD_W-1:0]     td_mag;
	logic signed [VOTE_W:0]     vote_wide;
	logic signed [VOTE_W-1:0]   vote_next;
	assign td_mag = (td_q < 0) ? -td_q : td_q;
	always_comb begin
		if (td_mag > b4_s) vote_wide = (VOTE_W+1)'(vote_cur_q) + (VOTE_W+1)'(VOTE_LATE);
		else vote_wide = (VOTE_W+1)'(vote_cur_q) - (VOTE_W+1)'(1);
		if (vote_wide > (VOTE_W+1)'(32767)) vote_next = VOTE_W'(32767);
		else if (vote_wide < -(VOTE_W+1)'(32768)) vote_next = VOTE_W'(-32768);
		else vote_next = VOTE_W'(vote_wide);
	end

	// Three-window sum
	logic signed [VOTE_W+1:0] vote_sum;
	assign vote_sum = (VOTE_W+2)'(vote_cur_q) + (VOTE_W+2)'(vote_prev_q)
		+ (VOTE_W+2)'(vote_old_q);

	logic word_room;
	assign word_room = (n_q < CW'(MAX_WORDS));

	// Status
	assign stat.fold_needed = (td_q >= $signed(TD_W'(USEC_HALF)));
	assign stat.step_needed = (td_q >= b2_s);
	assign stat.more_words  = (rp_q < n_q);
	assign stat.out_free    = !out_valid_q || out_ready;

	// Event payload and phase error
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			td_q  <= td_raw;
			lvl_q <= line_level;
		end else if (cmd.fold) begin
			td_q <= td_q - TD_W'(USEC_WRAP);
		end else if (cmd.step) begin
			td_q <= td_q - per_s;
		end
	end

	// Bit clock phase, shifter and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			shifter_q    <= '0;
			prev_level_q <= 1'b0;
		end else if (cmd.step) begin
			phase_q <= ph_step;
			if (shifter_q[0]) shifter_q <= SHIFT_W'(1) << (SHIFT_W - 2);
			else shifter_q <= shifter_q >> 1;
		end else if (cmd.trans && (prev_level_q != lvl_q)) begin
			phase_q      <= ph_nudge;
			shifter_q    <= shifter_q | (SHIFT_W'(1) << (SHIFT_W - 1));
			prev_level_q <= lvl_q;
		end
	end

	// Vote countdown, windows and carrier flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			vote_cur_q  <= '0;
			vote_prev_q <= '0;
			vote_old_q  <= '0;
			carrier_q   <= 1'b0;
		end else if (cmd.step) begin
			if (countdown_q != VOTE_W'(-32768)) countdown_q <= countdown_q - VOTE_W'(1);
		end else if (cmd.vote) begin
			if (countdown_q <= 0) begin
				if (soft_enable) carrier_q <= (vote_sum < 0);
				vote_old_q  <= vote_prev_q;
				vote_prev_q <= vote_cur_q;
				vote_cur_q  <= VOTE_W'(VOTE_SEED);
				countdown_q <= countdown_q + VOTE_W'(VOTE_WINDOW);
			end
		end else if (cmd.trans && (prev_level_q != lvl_q)) begin
			vote_cur_q <= vote_next;
		end
	end

	// Word count, read pointer and overrun
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			rp_q  <= '0;
			ovr_q <= 1'b0;
		end else if (cmd.capture) begin
			n_q   <= '0;
			rp_q  <= '0;
			ovr_q <= 1'b0;
		end else if (cmd.step && shifter_q[0]) begin
			if (word_room) n_q <= n_q + CW'(1);
			else ovr_q <= 1'b1;
		end else if (cmd.load_word) begin
			rp_q <= rp_q + CW'(1);
		end
	end

	// Word buffer
	always_ff @(posedge clk) begin
		if (cmd.step && shifter_q[0] && word_room) begin
			word_mem[n_q[AW-1:0]] <= ~shifter_q[SHIFT_W-1:1];
		end
		if (cmd.rd_issue) rd_data_q <= word_mem[rp_q[AW-1:0]];
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_word || cmd.load_status) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			word_q        <= rd_data_q;
			word_valid_q  <= 1'b1;
			carrier_out_q <= carrier_q;
			overrun_q     <= 1'b0;
			last_q        <= 1'b0;
		end else if (cmd.load_status) begin
			word_q        <= '0;
			word_valid_q  <= 1'b0;
			carrier_out_q <= carrier_q;
			overrun_q     <= ovr_q;
			last_q        <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign received_word = word_q;
	assign word_valid    = word_valid_q;
	assign carrier       = carrier_out_q;
	assign overrun       = overrun_q;
	assign last          = last_q;

endmodule
`default_nettype wire

FILE: hdl/edge_timed_dpll_nrzi_receiver.sv
// The per-period loop advances one bit period per cycle; the word buffer is read once per word.
// One event at a time: the next is taken once its status request is in the output register.
// Reset (arst_n, asynchronous): phase, shifter, level, votes and carrier clear; bit period 833,
// soft carrier enabled; no clearing pass.
`default_nettype none
module edge_timed_dpll_nrzi_receiver #(
	parameter int unsigned MAX_WORDS_PER_EVENT = etdnr_pkg::MAX_WORDS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [etdnr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [etdnr_pkg::PERIOD_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [etdnr_pkg::TS_W-1:0]          timestamp_us,
	input  wire logic                                line_level,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [etdnr_pkg::WORD_W-1:0]             received_word,
	output logic                                     word_valid,
	output logic                                     carrier,
	output logic                                     overrun,
	output logic                                     last
);
	import etdnr_pkg::*;

	logic [PERIOD_W-1:0] bit_period_q;
	logic                soft_enable_q;
	etdnr_cmd_t          cmd;
	etdnr_stat_t         stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q  <= PERIOD_W'(PERIOD_RESET);
			soft_enable_q <= 1'b1;
		end else if (cfg_wen) begin
			if (cfg_index == REG_BIT_PERIOD) bit_period_q <= cfg_data;
			else if (cfg_index == REG_SOFT_CARRIER) soft_enable_q <= cfg_data[0];
		end
	end

	etdnr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	etdnr_dp #(
		.MAX_WORDS (MAX_WORDS_PER_EVENT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.bit_period    (bit_period_q),
		.soft_enable   (soft_enable_q),
		.timestamp_us  (timestamp_us),
		.line_level    (line_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.received_word (received_word),
		.word_valid    (word_valid),
		.carrier       (carrier),
		.overrun       (overrun),
		.last          (last)
	);

endmodule
`default_nettype wire
